// ===== hw/rtl/kcac_pkg.sv =====
// shared constants and types for the keypad code alarm controller
package kcac_pkg;

  localparam int CODE_KEYS  = 6;
  localparam int MENU_ITEMS = 5;

  localparam int CODE_W = 4 * CODE_KEYS;
  localparam int CNT_W  = (CODE_KEYS > 1) ? $clog2(CODE_KEYS) : 1;
  localparam int MENU_W = $clog2(MENU_ITEMS + 1);

  // action codes
  localparam logic [1:0] ACT_KEY    = 2'd0;
  localparam logic [1:0] ACT_ARM    = 2'd1;
  localparam logic [1:0] ACT_DISARM = 2'd2;
  localparam logic [1:0] ACT_MOTION = 2'd3;

  // key codes
  localparam logic [3:0] K_ZERO = 4'd0;
  localparam logic [3:0] K_A    = 4'd10;
  localparam logic [3:0] K_B    = 4'd11;
  localparam logic [3:0] K_C    = 4'd12;
  localparam logic [3:0] K_D    = 4'd13;
  localparam logic [3:0] K_STAR = 4'd14;
  localparam logic [3:0] K_HASH = 4'd15;

  // event codes
  localparam logic [3:0] EV_NONE          = 4'd0;
  localparam logic [3:0] EV_DIGIT         = 4'd1;
  localparam logic [3:0] EV_SAVED         = 4'd2;
  localparam logic [3:0] EV_MISMATCH      = 4'd3;
  localparam logic [3:0] EV_ARMED         = 4'd4;
  localparam logic [3:0] EV_ARM_DENIED    = 4'd5;
  localparam logic [3:0] EV_DISARMED      = 4'd6;
  localparam logic [3:0] EV_DISARM_DENIED = 4'd7;
  localparam logic [3:0] EV_MASTER_OK     = 4'd8;
  localparam logic [3:0] EV_MASTER_DENIED = 4'd9;
  localparam logic [3:0] EV_MENU_MOVED    = 4'd10;
  localparam logic [3:0] EV_MOTION_ALARM  = 4'd11;
  localparam logic [3:0] EV_STATUS        = 4'd12;

  typedef struct packed {
    logic [1:0] action;
    logic [3:0] key_code;
    logic       motion;
  } kcac_item_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } kcac_hs_t;

endpackage

// ===== hw/rtl/kcac_if.sv =====
// channel interfaces for the input and result transactions
interface kcac_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [3:0] key_code;
  logic       motion;

  modport source (output valid, output action, output key_code, output motion, input ready);
  modport sink (input valid, input action, input key_code, input motion, output ready);
endinterface

interface kcac_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] event_res;
  logic [2:0] mode_now;
  logic [2:0] digits_now;
  logic [2:0] menu_item;
  logic       siren;
  logic       armed_lamp;
  logic       disarmed_lamp;

  modport source (output valid, output event_res, output mode_now, output digits_now,
                  output menu_item, output siren, output armed_lamp, output disarmed_lamp,
                  input ready);
  modport sink (input valid, input event_res, input mode_now, input digits_now,
                input menu_item, input siren, input armed_lamp, input disarmed_lamp,
                output ready);
endinterface

// ===== hw/rtl/keypad_code_alarm_controller_unit.sv =====
// an accepted input transaction is held in the input register, then lands in the result register
// throughput: one transaction per cycle while the result side is ready, set by the input register and result register
// the mode machine is combinational between those two registers
// reset (synchronous, rst_n low) clears mode to setup entry, key count, menu item to one,
// siren and both valid flags; the code stores hold no reset value until written
module keypad_code_alarm_controller_unit
  import kcac_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  kcac_in_if.sink     in_ch,
  kcac_out_if.source  out_ch
);

  // handshake between input register and core
  kcac_hs_t   stage_hs;
  kcac_item_t stage_item;
  logic       core_ready;

  // input register: decouples the keypad side from the mode machine
  kcac_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .down_ready (core_ready),
    .hs         (stage_hs),
    .item       (stage_item)
  );

  // mode machine with code stores and the result register
  kcac_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (stage_hs.valid),
    .item       (stage_item),
    .item_ready (core_ready),
    .out_ch     (out_ch)
  );

endmodule

// ===== hw/rtl/kcac_in_stage.sv =====
// input register stage for incoming transactions
module kcac_in_stage
  import kcac_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  kcac_in_if.sink     in_ch,
  input  logic        down_ready,
  output kcac_hs_t    hs,
  output kcac_item_t  item
);

  logic       valid_r;
  logic       valid_nxt;
  kcac_item_t item_r;
  logic       take;

  assign in_ch.ready = !valid_r || down_ready;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (down_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= '{action: in_ch.action, key_code: in_ch.key_code, motion: in_ch.motion};
    end
  end

  assign hs.valid = valid_r;
  assign hs.ready = down_ready;
  assign item     = item_r;

endmodule

// ===== hw/rtl/kcac_core.sv =====
// mode machine, code stores and result register
module kcac_core
  import kcac_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        item_valid,
  input  kcac_item_t  item,
  output logic        item_ready,
  kcac_out_if.source  out_ch
);

  typedef enum logic [2:0] {
    M_SETUP        = 3'd0,
    M_CONFIRM      = 3'd1,
    M_DISARMED     = 3'd2,
    M_ARM_ENTRY    = 3'd3,
    M_ARMED        = 3'd4,
    M_DISARM_ENTRY = 3'd5,
    M_MASTER       = 3'd6,
    M_MENU         = 3'd7
  } mode_t;

  mode_t              mode_r, mode_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [MENU_W-1:0]  pos_r, pos_nxt;
  logic               siren_r, siren_nxt;
  logic [CODE_W-1:0]  saved_r, saved_nxt;
  logic [CODE_W-1:0]  first_r, first_nxt;
  logic [CODE_W-1:0]  entry_r, entry_nxt;

  logic               ovalid_r;
  logic [3:0]         ev_r, ev_nxt;
  logic [2:0]         omode_r;
  logic [2:0]         odigits_r;
  logic [2:0]         omenu_r;
  logic               osiren_r;
  logic               oarmed_r;
  logic               odisarmed_r;

  logic               fire;
  logic               take_key;
  logic               done;
  logic [CODE_W-1:0]  shifted;
  logic [7:0]         cnt_wide;
  logic [7:0]         pos_wide;

  assign item_ready = !ovalid_r || out_ch.ready;
  assign fire       = item_valid && item_ready;

  assign shifted  = (entry_r << 4) | CODE_W'(item.key_code);
  assign done     = (cnt_r == CNT_W'(CODE_KEYS - 1));

  always_comb begin
    mode_nxt  = mode_r;
    cnt_nxt   = cnt_r;
    pos_nxt   = pos_r;
    siren_nxt = siren_r;
    saved_nxt = saved_r;
    first_nxt = first_r;
    entry_nxt = entry_r;
    ev_nxt    = EV_NONE;
    take_key  = 1'b0;

    case (item.action)
      ACT_KEY: begin
        // entry modes take every key
        if (mode_r == M_SETUP || mode_r == M_CONFIRM || mode_r == M_ARM_ENTRY ||
            mode_r == M_DISARM_ENTRY || mode_r == M_MASTER) begin
          take_key  = 1'b1;
          entry_nxt = shifted;
          cnt_nxt   = done ? '0 : cnt_r + CNT_W'(1);
          ev_nxt    = EV_DIGIT;
        end
        case (mode_r)
          M_SETUP: begin
            if (done) begin
              first_nxt = shifted;
              mode_nxt  = M_CONFIRM;
            end
          end
          M_CONFIRM: begin
            if (done) begin
              if (shifted == first_r) begin
                saved_nxt = shifted;
                mode_nxt  = M_DISARMED;
                ev_nxt    = EV_SAVED;
              end else begin
                mode_nxt = M_SETUP;
                ev_nxt   = EV_MISMATCH;
              end
            end
          end
          M_DISARMED: begin
            if (item.key_code == K_A) begin
              mode_nxt = M_ARM_ENTRY;
              cnt_nxt  = '0;
            end else if (item.key_code == K_C) begin
              mode_nxt = M_MASTER;
              cnt_nxt  = '0;
            end else if (item.key_code == K_D) begin
              mode_nxt = M_DISARM_ENTRY;
              cnt_nxt  = '0;
            end else if (item.key_code == K_B) begin
              ev_nxt = EV_STATUS;
            end
          end
          M_ARM_ENTRY: begin
            if (done) begin
              if (shifted == saved_r) begin
                mode_nxt = M_ARMED;
                ev_nxt   = EV_ARMED;
              end else begin
                mode_nxt = M_DISARMED;
                ev_nxt   = EV_ARM_DENIED;
              end
            end
          end
          M_ARMED: begin
            if (item.key_code == K_D) begin
              mode_nxt = M_DISARM_ENTRY;
              cnt_nxt  = '0;
            end
          end
          M_DISARM_ENTRY: begin
            if (done) begin
              if (shifted == saved_r) begin
                mode_nxt  = M_DISARMED;
                siren_nxt = 1'b0;
                ev_nxt    = EV_DISARMED;
              end else begin
                mode_nxt = M_ARMED;
                ev_nxt   = EV_DISARM_DENIED;
              end
            end
          end
          M_MASTER: begin
            if (done) begin
              if (shifted == saved_r) begin
                mode_nxt = M_MENU;
                pos_nxt  = MENU_W'(1);
                ev_nxt   = EV_MASTER_OK;
              end else begin
                mode_nxt = M_DISARMED;
                ev_nxt   = EV_MASTER_DENIED;
              end
            end
          end
          M_MENU: begin
            if (item.key_code == K_HASH) begin
              pos_nxt = (pos_r >= MENU_W'(MENU_ITEMS)) ? MENU_W'(1) : pos_r + MENU_W'(1);
              ev_nxt  = EV_MENU_MOVED;
            end else if (item.key_code == K_STAR) begin
              pos_nxt = (pos_r <= MENU_W'(1)) ? MENU_W'(MENU_ITEMS) : pos_r - MENU_W'(1);
              ev_nxt  = EV_MENU_MOVED;
            end else if (item.key_code == K_ZERO) begin
              // first item restarts code setup
              mode_nxt = (pos_r == MENU_W'(1)) ? M_SETUP : M_DISARMED;
              cnt_nxt  = '0;
              ev_nxt   = EV_STATUS;
            end
          end
          default: begin
            mode_nxt = mode_r;
          end
        endcase
      end
      ACT_ARM: begin
        if (mode_r == M_DISARMED) begin
          mode_nxt = M_ARM_ENTRY;
          cnt_nxt  = '0;
        end
      end
      ACT_DISARM: begin
        if (mode_r == M_DISARMED || mode_r == M_ARMED) begin
          mode_nxt = M_DISARM_ENTRY;
          cnt_nxt  = '0;
        end
      end
      ACT_MOTION: begin
        if (item.motion && (mode_r == M_ARMED || mode_r == M_DISARM_ENTRY)) begin
          siren_nxt = 1'b1;
          ev_nxt    = EV_MOTION_ALARM;
        end
      end
      default: begin
        ev_nxt = EV_NONE;
      end
    endcase
  end

  assign cnt_wide = 8'(cnt_nxt);
  assign pos_wide = 8'(pos_nxt);

  // control state and valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_SETUP;
      cnt_r    <= '0;
      pos_r    <= MENU_W'(1);
      siren_r  <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      if (fire) begin
        mode_r   <= mode_nxt;
        cnt_r    <= cnt_nxt;
        pos_r    <= pos_nxt;
        siren_r  <= siren_nxt;
        ovalid_r <= 1'b1;
      end else if (out_ch.ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  // code stores and result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      saved_r     <= saved_nxt;
      first_r     <= first_nxt;
      if (take_key) begin
        entry_r <= entry_nxt;
      end
      ev_r        <= ev_nxt;
      omode_r     <= mode_nxt;
      odigits_r   <= cnt_wide[2:0];
      omenu_r     <= pos_wide[2:0];
      osiren_r    <= siren_nxt;
      oarmed_r    <= (mode_nxt == M_ARMED) || (mode_nxt == M_DISARM_ENTRY);
      odisarmed_r <= (mode_nxt == M_DISARMED);
    end
  end

  assign out_ch.valid         = ovalid_r;
  assign out_ch.event_res     = ev_r;
  assign out_ch.mode_now      = omode_r;
  assign out_ch.digits_now    = odigits_r;
  assign out_ch.menu_item     = omenu_r;
  assign out_ch.siren         = osiren_r;
  assign out_ch.armed_lamp    = oarmed_r;
  assign out_ch.disarmed_lamp = odisarmed_r;

endmodule

// ===== tb/kcac_alarm_monitor.sv =====
`timescale 1ns / 1ps
// result predictor and checker for the keypad code alarm controller
module kcac_alarm_monitor
  import kcac_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  kcac_in_if   in_ch,
  kcac_out_if  out_ch,
  output int   fail_count,
  output int   pending
);

  typedef enum logic [2:0] {
    MODE_SETUP,
    MODE_CONFIRM,
    MODE_DISARMED,
    MODE_ARM_ENTRY,
    MODE_ARMED,
    MODE_DISARM_ENTRY,
    MODE_MASTER,
    MODE_MENU
  } alarm_mode_t;

  typedef struct packed {
    logic [3:0] event_res;
    logic [2:0] mode_now;
    logic [2:0] digits_now;
    logic [2:0] menu_item;
    logic       siren;
    logic       armed_lamp;
    logic       disarmed_lamp;
  } alarm_result_t;

  alarm_mode_t       mode = MODE_SETUP;
  logic [CODE_W-1:0] saved_code = '0;
  logic [CODE_W-1:0] first_entry = '0;
  logic [CODE_W-1:0] entry_keys = '0;
  int                key_count = 0;
  int                menu_pos = 1;
  logic              siren_on = 1'b0;

  alarm_result_t     alarm_results_due[$];
  int                mismatches = 0;
  int                outstanding = 0;

  assign fail_count = mismatches;
  assign pending    = outstanding;

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t kcac_alarm_monitor: %s", $time, what);
  endtask

  function automatic void open_entry(input alarm_mode_t m);
    mode = m;
    key_count = 0;
  endfunction

  // shifts one key into the entry, newest key lowest; true once the entry is full
  function automatic bit shift_key(input logic [3:0] k);
    entry_keys = {entry_keys[CODE_W-5:0], k};
    key_count++;
    if (key_count >= CODE_KEYS) begin
      key_count = 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [3:0] apply_key(input logic [3:0] k);
    case (mode)
      MODE_SETUP: begin
        if (shift_key(k)) begin
          first_entry = entry_keys;
          mode = MODE_CONFIRM;
        end
        return EV_DIGIT;
      end
      MODE_CONFIRM: begin
        if (!shift_key(k)) return EV_DIGIT;
        if (entry_keys == first_entry) begin
          saved_code = entry_keys;
          mode = MODE_DISARMED;
          return EV_SAVED;
        end
        mode = MODE_SETUP;
        return EV_MISMATCH;
      end
      MODE_DISARMED: begin
        if (k == K_A) open_entry(MODE_ARM_ENTRY);
        else if (k == K_C) open_entry(MODE_MASTER);
        else if (k == K_D) open_entry(MODE_DISARM_ENTRY);
        else if (k == K_B) return EV_STATUS;
        return EV_NONE;
      end
      MODE_ARM_ENTRY: begin
        if (!shift_key(k)) return EV_DIGIT;
        if (entry_keys == saved_code) begin
          mode = MODE_ARMED;
          return EV_ARMED;
        end
        mode = MODE_DISARMED;
        return EV_ARM_DENIED;
      end
      MODE_ARMED: begin
        if (k == K_D) open_entry(MODE_DISARM_ENTRY);
        return EV_NONE;
      end
      MODE_DISARM_ENTRY: begin
        if (!shift_key(k)) return EV_DIGIT;
        if (entry_keys == saved_code) begin
          mode = MODE_DISARMED;
          siren_on = 1'b0;
          return EV_DISARMED;
        end
        mode = MODE_ARMED;
        return EV_DISARM_DENIED;
      end
      MODE_MASTER: begin
        if (!shift_key(k)) return EV_DIGIT;
        if (entry_keys == saved_code) begin
          mode = MODE_MENU;
          menu_pos = 1;
          return EV_MASTER_OK;
        end
        mode = MODE_DISARMED;
        return EV_MASTER_DENIED;
      end
      default: begin
        if (k == K_HASH) begin
          menu_pos = (menu_pos >= MENU_ITEMS) ? 1 : menu_pos + 1;
          return EV_MENU_MOVED;
        end
        if (k == K_STAR) begin
          menu_pos = (menu_pos <= 1) ? MENU_ITEMS : menu_pos - 1;
          return EV_MENU_MOVED;
        end
        if (k == K_ZERO) begin
          if (menu_pos == 1) open_entry(MODE_SETUP);
          else open_entry(MODE_DISARMED);
          return EV_STATUS;
        end
        return EV_NONE;
      end
    endcase
  endfunction

  function automatic alarm_result_t next_alarm_result(input logic [1:0] act,
                                                      input logic [3:0] k,
                                                      input logic mot);
    alarm_result_t r;
    r.event_res = EV_NONE;
    case (act)
      ACT_KEY: r.event_res = apply_key(k);
      ACT_ARM: if (mode == MODE_DISARMED) open_entry(MODE_ARM_ENTRY);
      ACT_DISARM: begin
        if (mode == MODE_DISARMED || mode == MODE_ARMED) open_entry(MODE_DISARM_ENTRY);
      end
      default: begin
        if (mot && (mode == MODE_ARMED || mode == MODE_DISARM_ENTRY)) begin
          siren_on = 1'b1;
          r.event_res = EV_MOTION_ALARM;
        end
      end
    endcase
    r.mode_now      = mode;
    r.digits_now    = key_count[2:0];
    r.menu_item     = menu_pos[2:0];
    r.siren         = siren_on;
    r.armed_lamp    = (mode == MODE_ARMED || mode == MODE_DISARM_ENTRY);
    r.disarmed_lamp = (mode == MODE_DISARMED);
    return r;
  endfunction

  task automatic compare_result(input alarm_result_t want);
    if (out_ch.event_res !== want.event_res || out_ch.mode_now !== want.mode_now ||
        out_ch.digits_now !== want.digits_now || out_ch.menu_item !== want.menu_item ||
        out_ch.siren !== want.siren || out_ch.armed_lamp !== want.armed_lamp ||
        out_ch.disarmed_lamp !== want.disarmed_lamp) begin
      report_mismatch({
        $sformatf("got ev %0d mode %0d keys %0d item %0d siren %b lamps %b%b",
                  out_ch.event_res, out_ch.mode_now, out_ch.digits_now, out_ch.menu_item,
                  out_ch.siren, out_ch.armed_lamp, out_ch.disarmed_lamp),
        $sformatf(", want ev %0d mode %0d keys %0d item %0d siren %b lamps %b%b",
                  want.event_res, want.mode_now, want.digits_now, want.menu_item,
                  want.siren, want.armed_lamp, want.disarmed_lamp)});
    end
  endtask

  // results are checked before new inputs are predicted, so a result that appears together with its own input fails
  always @(posedge clk) begin
    if (!rst_n) begin
      mode        = MODE_SETUP;
      saved_code  = '0;
      first_entry = '0;
      entry_keys  = '0;
      key_count   = 0;
      menu_pos    = 1;
      siren_on    = 1'b0;
      alarm_results_due.delete();
      outstanding <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (alarm_results_due.size() == 0) begin
          report_mismatch("result transaction with nothing outstanding");
        end else begin
          compare_result(alarm_results_due.pop_front());
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        alarm_results_due.push_back(next_alarm_result(in_ch.action, in_ch.key_code,
                                                      in_ch.motion));
      end
      outstanding <= alarm_results_due.size();
    end
  end

endmodule

// ===== tb/tb_keypad_code_alarm_controller_unit.sv =====
`timescale 1ns / 1ps
// stimulus and verdict for the keypad code alarm controller
module tb_keypad_code_alarm_controller_unit;
  import kcac_pkg::*;

  // number of counted transactions in the random part; noise transactions come on top
  localparam int RANDOM_ITEMS = 660;
  // code saved by the directed part: covers hash, zero, a, d, a plain digit and star
  localparam logic [CODE_W-1:0] FIRST_CODE = 24'hF0AD5E;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;

  kcac_in_if  in_ch ();
  kcac_out_if out_ch ();

  keypad_code_alarm_controller_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // watches both channels, predicts every result and counts mismatches
  kcac_alarm_monitor u_monitor (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // stimulus-side view: the code the user believes is saved and the resting state
  logic [CODE_W-1:0] user_code;
  bit                alarm_on;
  int                menu_pos;
  int                burst_left = 0;
  int                items_sent = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop in case the block hangs or loses a transaction
  initial begin
    #5_000_000;
    $display("tb_keypad_code_alarm_controller_unit: FAIL");
    $finish;
  end

  // result side: the stall style is redrawn after a random run, one style never stalls
  initial begin
    int style;
    int left;
    style = 0;
    left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        style = $urandom_range(0, 3);
        left = $urandom_range(8, 64);
      end
      left--;
      case (style)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        2: out_ch.ready <= ($urandom_range(0, 4) != 0);
        default: out_ch.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // one input transaction; called at a rising edge, returns at the edge that accepted it
  task automatic push_item(input logic [1:0] act, input logic [3:0] k, input logic mot,
                           input bit counted);
    int gap;
    if (burst_left == 0) begin
      // idle gap with junk on the payload, then a new burst
      gap = $urandom_range(1, 6);
      in_ch.valid <= 1'b0;
      repeat (gap) begin
        in_ch.action   <= 2'($urandom_range(0, 3));
        in_ch.key_code <= 4'($urandom_range(0, 15));
        in_ch.motion   <= 1'($urandom_range(0, 1));
        @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    in_ch.valid    <= 1'b1;
    in_ch.action   <= act;
    in_ch.key_code <= k;
    in_ch.motion   <= mot;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    if (counted) items_sent++;
  endtask

  // unused payload fields get random values so every bit toggles
  task automatic press(input logic [3:0] k, input bit counted);
    push_item(ACT_KEY, k, 1'($urandom_range(0, 1)), counted);
  endtask

  task automatic pulse_line(input logic [1:0] act, input bit counted);
    push_item(act, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), counted);
  endtask

  task automatic sample_motion(input logic m, input bit counted);
    push_item(ACT_MOTION, 4'($urandom_range(0, 15)), m, counted);
  endtask

  // items that a code entry or the menu ignores, except motion in disarm entry
  task automatic entry_noise();
    case ($urandom_range(0, 2))
      0: pulse_line(ACT_ARM, 1'b0);
      1: pulse_line(ACT_DISARM, 1'b0);
      default: sample_motion(1'($urandom_range(0, 1)), 1'b0);
    endcase
  endtask

  // items that leave the resting state alone (status key, stray keys, motion)
  task automatic rest_noise();
    logic [3:0] k;
    case ($urandom_range(0, 2))
      0: begin
        do k = 4'($urandom_range(0, 15));
        while (k == K_D || (!alarm_on && (k == K_A || k == K_C)));
        press(k, 1'b0);
      end
      1: sample_motion(1'($urandom_range(0, 1)), 1'b0);
      default: begin
        if (alarm_on) pulse_line(ACT_ARM, 1'b0);
        else press(K_B, 1'b0);
      end
    endcase
  endtask

  // full code entry, first key is the top nibble; a corrupt entry differs in one key
  task automatic enter_code(input logic [CODE_W-1:0] code, input bit corrupt);
    logic [CODE_W-1:0] keys;
    logic [3:0]        flip;
    int                bad;
    int                i;
    keys = code;
    if (corrupt) begin
      bad = $urandom_range(0, CODE_KEYS - 1);
      flip = 4'($urandom_range(1, 15));
      keys[bad*4 +: 4] ^= flip;
    end
    for (i = CODE_KEYS - 1; i >= 0; i--) begin
      if ($urandom_range(0, 7) == 0) entry_noise();
      press(keys[i*4 +: 4], 1'b1);
    end
  endtask

  // pressure point: hold the sender until every expected result has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    burst_left = 0;
  endtask

  initial begin
    int                pick;
    bit                bad;
    bit                mid_drained;
    logic [CODE_W-1:0] next_code;

    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.action   = ACT_KEY;
    in_ch.key_code = K_ZERO;
    in_ch.motion   = 1'b0;
    mid_drained    = 1'b0;
    alarm_on       = 1'b0;
    menu_pos       = 1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: setup with all-hash first entry and an all-zero confirm (mismatch)
    repeat (CODE_KEYS) press(K_HASH, 1'b1);
    repeat (CODE_KEYS) press(K_ZERO, 1'b1);
    // matching pair saves the code, then a status request from disarmed
    enter_code(FIRST_CODE, 1'b0);
    enter_code(FIRST_CODE, 1'b0);
    user_code = FIRST_CODE;
    press(K_B, 1'b1);
    drain_results();

    // random part: mostly well-formed arm, disarm and menu sequences with random content
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (!mid_drained && items_sent >= RANDOM_ITEMS / 2) begin
        drain_results();
        mid_drained = 1'b1;
      end
      pick = $urandom_range(0, 9);
      if (pick < (alarm_on ? 4 : 2)) begin
        repeat ($urandom_range(1, 4)) rest_noise();
      end else if (!alarm_on && pick < 4) begin
        // arm by key or by request line; a wrong code falls back to disarmed
        if ($urandom_range(0, 1) == 0) press(K_A, 1'b1);
        else pulse_line(ACT_ARM, 1'b1);
        bad = ($urandom_range(0, 3) == 0);
        enter_code(user_code, bad);
        alarm_on = !bad;
      end else if (alarm_on || pick < 6) begin
        // disarm from either resting state; a wrong code leaves the block in armed mode
        if ($urandom_range(0, 1) == 0) press(K_D, 1'b1);
        else pulse_line(ACT_DISARM, 1'b1);
        bad = ($urandom_range(0, 3) == 0);
        enter_code(user_code, bad);
        alarm_on = bad;
      end else begin
        // master code, then a walk through the menu with wrap in both directions
        press(K_C, 1'b1);
        bad = ($urandom_range(0, 3) == 0);
        enter_code(user_code, bad);
        if (!bad) begin
          menu_pos = 1;
          repeat (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10)) begin
            case ($urandom_range(0, 3))
              0: begin
                press(K_HASH, 1'b1);
                menu_pos = (menu_pos >= MENU_ITEMS) ? 1 : menu_pos + 1;
              end
              1: begin
                press(K_STAR, 1'b1);
                menu_pos = (menu_pos <= 1) ? MENU_ITEMS : menu_pos - 1;
              end
              2: press(4'($urandom_range(1, 13)), 1'b0);
              default: entry_noise();
            endcase
          end
          press(K_ZERO, 1'b1);
          // item one restarts setup: a new code, sometimes with a mismatched confirm first
          if (menu_pos == 1) begin
            next_code = CODE_W'($urandom);
            if ($urandom_range(0, 3) == 0) begin
              enter_code(next_code, 1'b0);
              enter_code(next_code, 1'b1);
            end
            enter_code(next_code, 1'b0);
            enter_code(next_code, 1'b0);
            user_code = next_code;
          end
        end
      end
    end

    // wait out the last results plus the pipeline depth, then decide
    drain_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_keypad_code_alarm_controller_unit: PASS");
    end else begin
      $display("tb_keypad_code_alarm_controller_unit: FAIL");
    end
    $finish;
  end

endmodule
